// ===== rtl/sdiv_pkg.sv =====
// Package for the pipelined signed divider: shared stage types and constants.
// No dependencies; used by every module in rtl/.
`default_nettype none
package sdiv_pkg;
	localparam int unsigned OutWidth    = 64;
	localparam int unsigned NarrowWidth = 32;
	localparam int unsigned RadixBits   = 4;

	typedef enum logic {
		OP_DIV32 = 1'b0,
		OP_DIV64 = 1'b1
	} op_t;

	// Sideband flags that travel with every operand through the array.
	typedef struct packed {
		logic wide;
		logic nneg;
		logic qneg;
		logic zero;
	} sdiv_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/sdiv_stage.sv =====
// One pipeline stage of the restoring divider array: RadixBits quotient bits.
// Depends on sdiv_pkg.
`default_nettype none
module sdiv_stage #(
	parameter int unsigned W = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              stall,
	input  wire logic              in_valid,
	input  wire sdiv_pkg::sdiv_ctl_t in_ctl,
	input  wire logic [W-1:0]      in_rem,
	input  wire logic [W-1:0]      in_quo,
	input  wire logic [W-1:0]      in_den,
	output logic                   out_valid,
	output sdiv_pkg::sdiv_ctl_t    out_ctl,
	output logic [W-1:0]           out_rem,
	output logic [W-1:0]           out_quo,
	output logic [W-1:0]           out_den
);
	import sdiv_pkg::*;

	logic [W-1:0] rem_n;
	logic [W-1:0] quo_n;

	// The quotient register doubles as the dividend shift register.
	always_comb begin
		logic [W:0] trial;
		logic [W:0] diff;
		rem_n = in_rem;
		quo_n = in_quo;
		for (int i = 0; i < int'(RadixBits); i++) begin
			trial = {rem_n, quo_n[W-1]};
			diff  = trial - {1'b0, in_den};
			quo_n = {quo_n[W-2:0], ~diff[W]};
			rem_n = diff[W] ? trial[W-1:0] : diff[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!stall) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			out_ctl <= in_ctl;
			out_rem <= rem_n;
			out_quo <= quo_n;
			out_den <= in_den;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/signed_divider_32_64.sv =====
// Top level of the pipelined signed divider: operand prep, divider array, fixup.
// Depends on sdiv_pkg and sdiv_stage.
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | operation, numerator, denominator
//  out     | out_valid / out_stall| quotient, remainder, div_by_zero
//
// One transaction enters per cycle while out_stall is low; each result passes through the
// operand register, the chain of array stages (four quotient bits per stage) and the output
// register.
// Reset clears only the valid bits. A stall on the output freezes every stage
// at once, so no transaction is dropped or repeated; in_stall follows out_stall.
`default_nettype none
module signed_divider_32_64 #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        operation,
	input  wire logic [63:0] numerator,
	input  wire logic [63:0] denominator,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      quotient,
	output logic [63:0]      remainder,
	output logic             div_by_zero
);
	import sdiv_pkg::*;

	localparam int unsigned W      = DATA_WIDTH;
	localparam int unsigned Stages = (W + RadixBits - 1) / RadixBits;
	localparam int unsigned PadW   = Stages * RadixBits;

	// A full stall is safe: stage registers are the only storage.
	assign in_stall = out_stall;

	// Sign-extend the working bits to W, then form the control flags and operand magnitudes.
	logic [W-1:0] n_w, d_w, nm, dm;
	sdiv_ctl_t    ctl_in;
	always_comb begin
		if (operation == OP_DIV64) begin
			n_w = numerator[W-1:0];
			d_w = denominator[W-1:0];
		end else begin
			n_w = W'({{(64-NarrowWidth){numerator[NarrowWidth-1]}},
				numerator[NarrowWidth-1:0]});
			d_w = W'({{(64-NarrowWidth){denominator[NarrowWidth-1]}},
				denominator[NarrowWidth-1:0]});
		end
		ctl_in.wide = operation;
		ctl_in.nneg = n_w[W-1];
		ctl_in.qneg = n_w[W-1] ^ d_w[W-1];
		ctl_in.zero = (d_w == '0);
		nm = n_w[W-1] ? (W'(0) - n_w) : n_w;
		dm = d_w[W-1] ? (W'(0) - d_w) : d_w;
	end

	// Stage 1 register: magnitudes. Padding zeros sit above the dividend so
	// they shift out first and leave the quotient unchanged.
	logic         v_s1;
	sdiv_ctl_t    ctl_s1;
	logic [PadW-1:0] quo_s1, rem_s1, den_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!out_stall) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (!out_stall) begin
			ctl_s1 <= ctl_in;
			quo_s1 <= PadW'(nm);
			rem_s1 <= '0;
			den_s1 <= PadW'(dm);
		end
	end

	logic            v_a   [Stages+1];
	sdiv_ctl_t       ctl_a [Stages+1];
	logic [PadW-1:0] rem_a [Stages+1];
	logic [PadW-1:0] quo_a [Stages+1];
	logic [PadW-1:0] den_a [Stages+1];
	assign v_a[0]   = v_s1;
	assign ctl_a[0] = ctl_s1;
	assign rem_a[0] = rem_s1;
	assign quo_a[0] = quo_s1;
	assign den_a[0] = den_s1;

	for (genvar g = 0; g < Stages; g++) begin : g_stage
		sdiv_stage #(.W(PadW)) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.stall    (out_stall),
			.in_valid (v_a[g]),
			.in_ctl   (ctl_a[g]),
			.in_rem   (rem_a[g]),
			.in_quo   (quo_a[g]),
			.in_den   (den_a[g]),
			.out_valid(v_a[g+1]),
			.out_ctl  (ctl_a[g+1]),
			.out_rem  (rem_a[g+1]),
			.out_quo  (quo_a[g+1]),
			.out_den  (den_a[g+1])
		);
	end

	// Sign fixup, zero handling and width extension into the output register.
	sdiv_ctl_t    cf;
	logic [W-1:0] qm, rm, q_w, r_w;
	logic [63:0]  q64, r64;
	always_comb begin
		cf  = ctl_a[Stages];
		qm  = quo_a[Stages][W-1:0];
		rm  = rem_a[Stages][W-1:0];
		q_w = cf.qneg ? (W'(0) - qm) : qm;
		r_w = cf.nneg ? (W'(0) - rm) : rm;
		if (cf.zero) begin
			q_w = cf.nneg ? W'(1) : '1;
		end
		if (cf.wide) begin
			q64 = 64'($signed(q_w));
			r64 = 64'($signed(r_w));
		end else begin
			q64 = {{(64-NarrowWidth){q_w[NarrowWidth-1]}}, q_w[NarrowWidth-1:0]};
			r64 = {{(64-NarrowWidth){r_w[NarrowWidth-1]}}, r_w[NarrowWidth-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_stall) begin
			out_valid <= v_a[Stages];
		end
	end
	always_ff @(posedge clk) begin
		if (!out_stall) begin
			quotient    <= q64;
			remainder   <= r64;
			div_by_zero <= cf.zero;
		end
	end

	// On division by zero div_by_zero and out_valid must follow; the array remainder is the numerator magnitude.
	a_zero_q : assert property (@(posedge clk) disable iff (!arst_n)
		(v_a[Stages] && cf.zero && !out_stall) |=> (div_by_zero && out_valid))
		else $error("divide-by-zero flag lost");
	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(quotient)))
		else $error("stalled result changed");
	a_rem_lt : assert property (@(posedge clk) disable iff (!arst_n)
		(v_a[Stages] && !cf.zero) |-> (rem_a[Stages] < den_a[Stages]))
		else $error("remainder not below divisor");
endmodule
`default_nettype wire

// ===== dv/div_checker.sv =====
`timescale 1ns / 1ps
// Checker for the signed divider: watches both channels, predicts each result and compares.
// Depends on sdiv_pkg for the operation codes.
module div_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        operation,
	input  wire logic [63:0] numerator,
	input  wire logic [63:0] denominator,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [63:0] quotient,
	input  wire logic [63:0] remainder,
	input  wire logic        div_by_zero,
	output int               fail_count,
	output int               pending,
	output int               checked
);
	import sdiv_pkg::*;

	typedef struct packed {
		logic [63:0] quo;
		logic [63:0] rem;
		logic        dbz;
	} div_result_t;

	div_result_t expected_results[$];

	function automatic logic [63:0] widen(logic [63:0] v, logic wide);
		return wide ? v : {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic div_result_t divide(op_t op, logic [63:0] num, logic [63:0] den);
		div_result_t res;
		logic wide;
		logic [63:0] n, d, nm, dm, qm, rm, q, r;
		wide = (op == OP_DIV64);
		n = widen(num, wide);
		d = widen(den, wide);
		res.dbz = (d == 64'd0);
		if (res.dbz) begin
			q = n[63] ? 64'd1 : '1;
			r = n;
		end else begin
			nm = n[63] ? -n : n;
			dm = d[63] ? -d : d;
			qm = nm / dm;
			rm = nm % dm;
			q = widen((n[63] != d[63]) ? -qm : qm, wide);
			r = widen(n[63] ? -rm : rm, wide);
		end
		res.quo = q;
		res.rem = r;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		div_result_t want;
		if (!arst_n) begin
			fail_count <= 0;
			checked <= 0;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(divide(op_t'(operation), numerator, denominator));
			if (out_valid && !out_stall) begin
				checked <= checked + 1;
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("Unexpected result transaction: q=%h r=%h z=%b",
							quotient, remainder, div_by_zero);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (want.quo !== quotient || want.rem !== remainder
							|| want.dbz !== div_by_zero) begin
						if (fail_count < 10)
							$display("Mismatch: expected q=%h r=%h z=%b, got q=%h r=%h z=%b",
								want.quo, want.rem, want.dbz, quotient, remainder,
								div_by_zero);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_results.size();
		end
	end
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the signed divider testbench: clock, reset, stimulus and verdict.
// Depends on sdiv_pkg, signed_divider_32_64 and div_checker.
module testbench;
	import sdiv_pkg::*;

	localparam int RandomCount = 1400;
	localparam int CalmTail = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic operation = 1'b0;
	logic [63:0] numerator = '0;
	logic [63:0] denominator = '0;
	logic out_stall = 1'b0;
	logic in_stall, out_valid, div_by_zero;
	logic [63:0] quotient, remainder;
	int fail_count, pending, checked;
	bit calm = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	signed_divider_32_64 dut (.*);

	div_checker checker_i (.*);

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	// Random bursts of output stall, switched off near the end of the run.
	initial begin
		int n;
		while (1) begin
			n = $urandom_range(1, 10);
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				repeat (n) @(negedge clk);
			end
		end
	end

	function automatic logic [63:0] rand_operand(logic wide);
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = wide ? 64'h8000_0000_0000_0000 : {v[63:32], 32'h8000_0000};
			2: v = wide ? '1 : {v[63:32], 32'hffff_ffff};
			3: v = wide ? 64'h7fff_ffff_ffff_ffff : {v[63:32], 32'h7fff_ffff};
			4: v = v >> $urandom_range(1, 62);
			5: v = -(v >> $urandom_range(1, 62));
			6: v = {v[63:32], 32'd0};
			default: ;
		endcase
		return v;
	endfunction

	// Presents one transaction and holds it until accepted.
	task automatic send_division(op_t op, logic [63:0] num, logic [63:0] den);
		operation <= op;
		numerator <= num;
		denominator <= den;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic gap();
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
	endtask

	initial begin
		logic w;
		int waited;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int m = 0; m < 2; m++) begin
			op_t op;
			logic [63:0] maxneg, maxpos, junk;
			op = m ? OP_DIV64 : OP_DIV32;
			maxneg = m ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
			maxpos = m ? 64'h7fff_ffff_ffff_ffff : 64'h7fff_ffff;
			junk = m ? 64'd0 : 64'hdead_beef_0000_0000;
			send_division(op, 64'd100, 64'd7);
			send_division(op, -64'd100, 64'd7);
			send_division(op, 64'd100, -64'd7);
			send_division(op, -64'd100, -64'd7);
			send_division(op, maxneg, '1);
			send_division(op, maxneg | junk, 64'd1);
			send_division(op, maxpos, maxneg);
			send_division(op, 64'd5, junk);
			send_division(op, -64'd5, junk);
			send_division(op, 64'd0, junk);
			send_division(op, maxneg, junk);
			send_division(op, '1, '1);
		end
		for (int i = 0; i < RandomCount; i++) begin
			if (i == RandomCount - CalmTail) calm = 1'b1;
			w = $urandom_range(0, 1);
			gap();
			send_division(op_t'(w), rand_operand(w), rand_operand(w));
		end
		in_valid <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < 100000) begin
			@(negedge clk);
			waited++;
		end
		repeat (40) @(negedge clk);
		$display("Ran directed edge cases and %0d random divisions in both widths;", RandomCount);
		$display("%0d results checked, %0d still outstanding.", checked, pending);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
